### design/tev_pkg.sv
// ---------------------------------------------------------------------------
// tev_pkg: shared types and constants of the timed event priority queue
// Event record, result record, command and status codes, cell control.
// ---------------------------------------------------------------------------
`default_nettype none
package tev_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned MAX_RESULTS  = 33;
  localparam int unsigned MAX_DISPATCH = 32;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned IN_W         = 192;
  localparam int unsigned OUT_W        = 272;

  typedef enum logic [2:0] {
    K_INSERT    = 3'd0,
    K_REMOVE    = 3'd1,
    K_FIND_EVT  = 3'd2,
    K_FIND_CB   = 3'd3,
    K_TICK      = 3'd4,
    K_ADVANCE   = 3'd5,
    K_RSVD6     = 3'd6,
    K_RSVD7     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    S_OK       = 2'd0,
    S_FULL     = 2'd1,
    S_NOTFOUND = 2'd2,
    S_DISPATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMD, ST_DRAIN, ST_ADV, ST_FIN, ST_RD, ST_OUT
  } state_e;

  typedef struct packed {
    logic [63:0]        due;
    logic signed [15:0] prio;
    logic [7:0]         tag;
    logic [2:0]         etype;
    logic [7:0]         recip;
    logic [15:0]        req;
    logic [7:0]         cb;
    logic [31:0]        data;
  } ev_t;

  typedef struct packed {
    cell_op_e           op;
    kind_e              kind;
    ev_t                q;
    logic [IDX_W-1:0]   rm_idx;
  } cell_ctl_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  tag;
    logic [2:0]  etype;
    logic [7:0]  recip;
    logic [15:0] req;
    logic [7:0]  cb;
    logic [31:0] data;
    logic [63:0] elapsed;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage
`default_nettype wire

### design/tev_ram.sv
// ---------------------------------------------------------------------------
// tev_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module tev_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/tev_cell.sv
// ---------------------------------------------------------------------------
// tev_cell: one slot of the sorted event chain
// Holds one event, compares it with the request, and shifts for insert/remove.
// ---------------------------------------------------------------------------
`default_nettype none
module tev_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tev_pkg::cell_ctl_t ctl_i,
  input  wire tev_pkg::ev_t      left_ev_i,
  input  wire logic              left_vld_i,
  input  wire logic              left_b_i,
  input  wire tev_pkg::ev_t      right_ev_i,
  input  wire logic              right_vld_i,
  output tev_pkg::ev_t           ev_o,
  output logic                   vld_o,
  output logic                   b_o,
  output logic                   hit_o
);
  tev_pkg::ev_t ev_q, ev_d;
  logic         vld_q, vld_d;
  logic         key_hit;

  assign ev_o  = ev_q;
  assign vld_o = vld_q;

  always_comb begin
    b_o = !vld_q || (ctl_i.q.due < ev_q.due) ||
          ((ctl_i.q.due == ev_q.due) && (ctl_i.q.prio < ev_q.prio));
  end

  always_comb begin
    case (ctl_i.kind)
      tev_pkg::K_REMOVE:   key_hit = ev_q.tag == ctl_i.q.tag;
      tev_pkg::K_FIND_EVT: key_hit = (ev_q.etype == ctl_i.q.etype) &&
                                     (ev_q.recip == ctl_i.q.recip) &&
                                     (ev_q.req == ctl_i.q.req);
      tev_pkg::K_FIND_CB:  key_hit = (ev_q.recip == ctl_i.q.recip) &&
                                     (ev_q.cb == ctl_i.q.cb) &&
                                     (ev_q.data == ctl_i.q.data) &&
                                     (ev_q.prio == ctl_i.q.prio);
      default:             key_hit = 1'b0;
    endcase
    hit_o = vld_q && (ev_q.due == ctl_i.q.due) && key_hit;
  end

  always_comb begin
    ev_d  = ev_q;
    vld_d = vld_q;
    case (ctl_i.op)
      tev_pkg::OP_INS: begin
        if (b_o) begin
          vld_d = left_b_i ? left_vld_i : 1'b1;
          ev_d  = left_b_i ? left_ev_i : ctl_i.q;
        end
      end
      tev_pkg::OP_REM: begin
        if (tev_pkg::IDX_W'(IDX) >= ctl_i.rm_idx) begin
          vld_d = right_vld_i;
          ev_d  = right_ev_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end
endmodule
`default_nettype wire

### design/timed_event_priority_queue.sv
// ---------------------------------------------------------------------------
// timed_event_priority_queue: sorted chain of timed events
// Insert, remove, find, tick and advance over a chain kept in service order.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: kind; tdata: request fields
//  m_axis    out        tdata: result fields; tlast: final result of a request
//
//  Requests are decoded in ST_CMD. Tick and advance then dispatch due events
//  from the head, jump to event groups, make a final jump, and end with the
//  last due check and the status result. Results are sent from a result RAM
//  after the work ends (registered read). A new request is taken only after
//  the last result of the previous one. Reset empties the chain.
`default_nettype none
module timed_event_priority_queue #(
  parameter int unsigned CAPACITY = tev_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // tag, due_cycle, priority_req, event_type, recipient, request_id,
  // callback_id, data_word, steps
  input  wire logic [tev_pkg::IN_W-1:0]  s_axis_tdata,
  // kind
  input  wire logic [2:0]                s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // status, out_tag, out_type, out_recipient, out_request, out_callback,
  // out_data, elapsed, now_cycle, next_due
  output logic [tev_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                           m_axis_tlast
);
  localparam logic [63:0] ALL_ONES = '1;

  tev_pkg::state_e   st_q, st_d;
  tev_pkg::kind_e    kind_q;
  tev_pkg::ev_t      rq_q;
  logic [31:0]       left_q, left_d;
  logic [63:0]       pc_q, pc_d;
  logic [63:0]       prev_q, prev_d;
  logic [63:0]       grp_due_q, grp_due_d;
  logic              grp_open_q, grp_open_d;
  logic [tev_pkg::CNT_W-1:0] wr_cnt_q, wr_cnt_d, rd_ptr_q, rd_ptr_d;

  tev_pkg::cell_ctl_t ctl;
  tev_pkg::ev_t      cell_ev  [CAPACITY];
  logic              cell_vld [CAPACITY];
  logic              cell_b   [CAPACITY];
  logic              cell_hit [CAPACITY];

  logic              ram_we;
  tev_pkg::res_t     ram_wdata, ram_rdata;

  logic [tev_pkg::IDX_W-1:0] first_idx, last_idx, hit_idx;
  logic              any_hit;
  tev_pkg::ev_t      head, sel;
  logic              head_due_now, dsp, full;
  logic [63:0]       prev_eff, gap;
  logic [64:0]       sum_one, sum_left;

  // ---- request capture ----
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q     <= tev_pkg::kind_e'(s_axis_tuser);
      rq_q.tag   <= s_axis_tdata[7:0];
      rq_q.due   <= s_axis_tdata[71:8];
      rq_q.prio  <= s_axis_tdata[87:72];
      rq_q.etype <= s_axis_tdata[90:88];
      rq_q.recip <= s_axis_tdata[98:91];
      rq_q.req   <= s_axis_tdata[114:99];
      rq_q.cb    <= s_axis_tdata[122:115];
      rq_q.data  <= s_axis_tdata[154:123];
    end
  end

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tev_pkg::ev_t l_ev, r_ev;
    logic         l_vld, l_b, r_vld;
    if (i == 0) begin : g_first
      assign l_ev  = '0;
      assign l_vld = 1'b0;
      assign l_b   = 1'b0;
    end else begin : g_mid
      assign l_ev  = cell_ev[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_b   = cell_b[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_ev  = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_ev  = cell_ev[i+1];
      assign r_vld = cell_vld[i+1];
    end
    tev_cell #(.IDX(i)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_ev_i  (l_ev),
      .left_vld_i (l_vld),
      .left_b_i   (l_b),
      .right_ev_i (r_ev),
      .right_vld_i(r_vld),
      .ev_o       (cell_ev[i]),
      .vld_o      (cell_vld[i]),
      .b_o        (cell_b[i]),
      .hit_o      (cell_hit[i])
    );
  end

  // ---- match selection ----
  always_comb begin
    any_hit   = 1'b0;
    first_idx = '0;
    last_idx  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        first_idx = tev_pkg::IDX_W'(i);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        last_idx = tev_pkg::IDX_W'(i);
        any_hit  = 1'b1;
      end
    end
    hit_idx = (kind_q == tev_pkg::K_FIND_EVT) ? last_idx : first_idx;
    sel     = cell_ev[hit_idx[$clog2(CAPACITY)-1:0]];
  end

  assign head         = cell_ev[0];
  assign full         = cell_vld[CAPACITY-1];
  assign head_due_now = cell_vld[0] && (head.due <= pc_q);
  assign dsp          = head_due_now && (wr_cnt_q < tev_pkg::CNT_W'(tev_pkg::MAX_DISPATCH));
  assign prev_eff     = (grp_open_q && (grp_due_q != head.due) && (grp_due_q > prev_q))
                        ? grp_due_q : prev_q;
  assign gap          = head.due - pc_q;
  assign sum_one      = {1'b0, pc_q} + 65'd1;
  assign sum_left     = {1'b0, pc_q} + {33'd0, left_q};

  // ---- next state ----
  always_comb begin
    st_d = st_q;
    case (st_q)
      tev_pkg::ST_IDLE: if (s_axis_tvalid) st_d = tev_pkg::ST_CMD;
      tev_pkg::ST_CMD: begin
        if (kind_q == tev_pkg::K_TICK || kind_q == tev_pkg::K_ADVANCE) begin
          st_d = tev_pkg::ST_DRAIN;
        end else begin
          st_d = tev_pkg::ST_RD;
        end
      end
      tev_pkg::ST_DRAIN: begin
        if (!dsp) begin
          if (kind_q == tev_pkg::K_TICK || head_due_now || left_q == '0) begin
            st_d = tev_pkg::ST_FIN;
          end else begin
            st_d = tev_pkg::ST_ADV;
          end
        end
      end
      tev_pkg::ST_ADV: begin
        if (!cell_vld[0] || (head.due < pc_q) || (gap > {32'd0, left_q})) begin
          st_d = tev_pkg::ST_FIN;
        end else begin
          st_d = tev_pkg::ST_DRAIN;
        end
      end
      tev_pkg::ST_FIN: st_d = tev_pkg::ST_RD;
      tev_pkg::ST_RD:  st_d = tev_pkg::ST_OUT;
      tev_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          st_d = (rd_ptr_q + 1'b1 == wr_cnt_q) ? tev_pkg::ST_IDLE : tev_pkg::ST_RD;
        end
      end
      default: st_d = tev_pkg::ST_IDLE;
    endcase
  end

  // ---- datapath control ----
  always_comb begin
    ctl.op     = tev_pkg::OP_HOLD;
    ctl.kind   = kind_q;
    ctl.q      = rq_q;
    ctl.rm_idx = '0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    ram_wdata.status = tev_pkg::S_OK;
    left_d     = left_q;
    pc_d       = pc_q;
    prev_d     = prev_q;
    grp_due_d  = grp_due_q;
    grp_open_d = grp_open_q;
    wr_cnt_d   = wr_cnt_q;
    rd_ptr_d   = rd_ptr_q;
    s_axis_tready = (st_q == tev_pkg::ST_IDLE);
    m_axis_tvalid = (st_q == tev_pkg::ST_OUT);
    if (s_axis_tvalid && s_axis_tready) begin
      left_d   = s_axis_tdata[186:155];
      wr_cnt_d = '0;
      rd_ptr_d = '0;
    end
    case (st_q)
      tev_pkg::ST_CMD: begin
        wr_cnt_d   = '0;
        rd_ptr_d   = '0;
        grp_open_d = 1'b0;
        case (kind_q)
          tev_pkg::K_INSERT: begin
            ram_we   = 1'b1;
            wr_cnt_d = tev_pkg::CNT_W'(1);
            if (full) begin
              ram_wdata.status = tev_pkg::S_FULL;
            end else begin
              ctl.op = tev_pkg::OP_INS;
            end
          end
          tev_pkg::K_REMOVE, tev_pkg::K_FIND_EVT, tev_pkg::K_FIND_CB: begin
            ram_we   = 1'b1;
            wr_cnt_d = tev_pkg::CNT_W'(1);
            if (any_hit) begin
              ram_wdata.tag   = sel.tag;
              ram_wdata.etype = sel.etype;
              ram_wdata.recip = sel.recip;
              ram_wdata.req   = sel.req;
              ram_wdata.cb    = sel.cb;
              ram_wdata.data  = sel.data;
              if (kind_q == tev_pkg::K_REMOVE) begin
                ctl.op     = tev_pkg::OP_REM;
                ctl.rm_idx = hit_idx;
              end
            end else begin
              ram_wdata.status = tev_pkg::S_NOTFOUND;
            end
          end
          tev_pkg::K_TICK, tev_pkg::K_ADVANCE: begin
          end
          default: begin
            ram_we   = 1'b1;
            wr_cnt_d = tev_pkg::CNT_W'(1);
          end
        endcase
      end
      tev_pkg::ST_DRAIN: begin
        if (dsp) begin
          ram_we           = 1'b1;
          ram_wdata.status = tev_pkg::S_DISPATCH;
          ram_wdata.tag    = head.tag;
          ram_wdata.etype  = head.etype;
          ram_wdata.recip  = head.recip;
          ram_wdata.req    = head.req;
          ram_wdata.cb     = head.cb;
          ram_wdata.data   = head.data;
          ram_wdata.elapsed = (head.due > prev_eff) ? head.due - prev_eff : '0;
          ctl.op     = tev_pkg::OP_REM;
          prev_d     = prev_eff;
          grp_open_d = 1'b1;
          grp_due_d  = head.due;
          wr_cnt_d   = wr_cnt_q + 1'b1;
        end else if (kind_q == tev_pkg::K_TICK) begin
          pc_d = sum_one[64] ? ALL_ONES : sum_one[63:0];
        end
      end
      tev_pkg::ST_ADV: begin
        if (!cell_vld[0] || (head.due < pc_q) || (gap > {32'd0, left_q})) begin
          pc_d = sum_left[64] ? ALL_ONES : sum_left[63:0];
        end else begin
          left_d = left_q - gap[31:0];
          pc_d   = head.due;
        end
      end
      tev_pkg::ST_FIN: begin
        ram_we   = 1'b1;
        wr_cnt_d = wr_cnt_q + 1'b1;
        if (grp_open_q && (grp_due_q > prev_q)) begin
          prev_d = grp_due_q;
        end
        grp_open_d = 1'b0;
      end
      tev_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  tev_ram #(
    .WIDTH(tev_pkg::RES_W),
    .DEPTH(tev_pkg::MAX_RESULTS)
  ) u_res_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_cnt_q),
    .wdata_i(ram_wdata),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[1:0]     = ram_rdata.status;
    m_axis_tdata[9:2]     = ram_rdata.tag;
    m_axis_tdata[12:10]   = ram_rdata.etype;
    m_axis_tdata[20:13]   = ram_rdata.recip;
    m_axis_tdata[36:21]   = ram_rdata.req;
    m_axis_tdata[44:37]   = ram_rdata.cb;
    m_axis_tdata[76:45]   = ram_rdata.data;
    m_axis_tdata[140:77]  = ram_rdata.elapsed;
    m_axis_tdata[204:141] = pc_q;
    m_axis_tdata[268:205] = cell_vld[0] ? head.due : ALL_ONES;
    m_axis_tlast          = (rd_ptr_q + 1'b1 == wr_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= tev_pkg::ST_IDLE;
      pc_q       <= '0;
      prev_q     <= '0;
      grp_open_q <= 1'b0;
      wr_cnt_q   <= '0;
      rd_ptr_q   <= '0;
    end else begin
      st_q       <= st_d;
      pc_q       <= pc_d;
      prev_q     <= prev_d;
      grp_open_q <= grp_open_d;
      wr_cnt_q   <= wr_cnt_d;
      rd_ptr_q   <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q    <= left_d;
    grp_due_q <= grp_due_d;
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while results pending");
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rd_ptr_q < wr_cnt_q))
    else $error("result read beyond written count");
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_q <= tev_pkg::CNT_W'(tev_pkg::MAX_RESULTS))
    else $error("result count overflow");
  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(pc_q))
    else $error("present cycle moved while result stalled");
`endif
endmodule
`default_nettype wire
